[hw/rtl/midpoint_line_rasterizer_core_macros.svh]
// Assertion macros shared by the line rasterizer checker.
`ifndef MIDPOINT_LINE_RASTERIZER_CORE_MACROS_SVH
`define MIDPOINT_LINE_RASTERIZER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MLR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/mlr_pkg.sv]
// Shared constants, types and codes of the midpoint line rasterizer.
package mlr_pkg;

    localparam int COORD_BITS  = 12;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int ACC_BITS    = COORD_BITS + 3;
    localparam int COLOUR_BITS = 24;

    localparam int S_FIELD_BITS = 4 * COORD_BITS + COLOUR_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 2 * COORD_BITS + COLOUR_BITS;
    localparam int M_DATA_BITS  = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [ACC_BITS-1:0]   t_acc;
    typedef logic [COLOUR_BITS-1:0]       t_colour;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        OCT_SHALLOW_UP   = 2'd0,
        OCT_SHALLOW_DOWN = 2'd1,
        OCT_STEEP_UP     = 2'd2,
        OCT_STEEP_DOWN   = 2'd3
    } t_octant;

    typedef struct packed {
        logic    active;
        t_coord  cur_x;
        t_coord  cur_y;
        t_coord  stop;
        t_acc    decision;
        t_acc    inc_straight;
        t_acc    inc_diagonal;
        t_octant octant;
    } t_line_state;

endpackage

[hw/rtl/mlr_setup.sv]
// Line setup: endpoint ordering, octant choice and initial decision terms.
module mlr_setup import mlr_pkg::*; (
    input  t_coord      i_start_x,
    input  t_coord      i_start_y,
    input  t_coord      i_end_x,
    input  t_coord      i_end_y,
    output t_line_state o_state,
    output logic        o_emit
);

    logic                        swap;
    t_coord                      x0;
    t_coord                      y0;
    t_coord                      x1;
    t_coord                      y1;
    logic signed [DIFF_BITS-1:0] dx;
    logic signed [DIFF_BITS-1:0] dy;
    logic signed [DIFF_BITS-1:0] ady;
    t_acc                        dx_e;
    t_acc                        dy_e;

    always_comb begin
        swap = i_start_x > i_end_x;
        x0   = swap ? i_end_x   : i_start_x;
        y0   = swap ? i_end_y   : i_start_y;
        x1   = swap ? i_start_x : i_end_x;
        y1   = swap ? i_start_y : i_end_y;
        dx   = DIFF_BITS'(x1) - DIFF_BITS'(x0);
        dy   = DIFF_BITS'(y1) - DIFF_BITS'(y0);
        ady  = dy[DIFF_BITS-1] ? -dy : dy;
        dx_e = ACC_BITS'(dx);
        dy_e = ACC_BITS'(dy);

        o_emit          = (dx != '0) || (dy != '0);
        o_state         = '0;
        o_state.active  = o_emit;
        o_state.cur_x   = x0;
        o_state.cur_y   = y0;

        if (ady <= dx) begin
            o_state.stop         = x1;
            o_state.inc_straight = dy_e <<< 1;
            if (!dy[DIFF_BITS-1]) begin
                o_state.octant       = OCT_SHALLOW_UP;
                o_state.decision     = (dy_e <<< 1) - dx_e;
                o_state.inc_diagonal = (dy_e - dx_e) <<< 1;
            end else begin
                o_state.octant       = OCT_SHALLOW_DOWN;
                o_state.decision     = (dy_e <<< 1) + dx_e;
                o_state.inc_diagonal = (dy_e + dx_e) <<< 1;
            end
        end else begin
            o_state.stop = y1;
            if (!dy[DIFF_BITS-1]) begin
                o_state.octant       = OCT_STEEP_UP;
                o_state.decision     = dy_e - (dx_e <<< 1);
                o_state.inc_straight = -(dx_e <<< 1);
                o_state.inc_diagonal = (dy_e - dx_e) <<< 1;
            end else begin
                o_state.octant       = OCT_STEEP_DOWN;
                o_state.decision     = dy_e + (dx_e <<< 1);
                o_state.inc_straight = dx_e <<< 1;
                o_state.inc_diagonal = (dy_e + dx_e) <<< 1;
            end
        end
    end

endmodule

[hw/rtl/mlr_step.sv]
// One midpoint step: next pixel, decision update and end-of-line test.
module mlr_step import mlr_pkg::*; (
    input  t_line_state i_state,
    output t_line_state o_state,
    output logic        o_done
);

    logic   dec_neg;
    logic   dec_zero;
    logic   diag;
    t_coord x_inc;
    t_coord y_inc;
    t_coord y_dec;

    always_comb begin
        dec_neg  = i_state.decision[ACC_BITS-1];
        dec_zero = (i_state.decision == '0);
        x_inc    = i_state.cur_x + COORD_BITS'(1);
        y_inc    = i_state.cur_y + COORD_BITS'(1);
        y_dec    = i_state.cur_y - COORD_BITS'(1);
        o_state  = i_state;
        o_done   = 1'b0;
        diag     = 1'b0;

        case (i_state.octant)
            OCT_SHALLOW_UP: begin
                diag          = !dec_neg && !dec_zero;
                o_state.cur_x = x_inc;
                o_state.cur_y = diag ? y_inc : i_state.cur_y;
                o_done        = (x_inc == i_state.stop);
            end
            OCT_SHALLOW_DOWN: begin
                diag          = dec_neg || dec_zero;
                o_state.cur_x = x_inc;
                o_state.cur_y = diag ? y_dec : i_state.cur_y;
                o_done        = (x_inc == i_state.stop);
            end
            OCT_STEEP_UP: begin
                diag          = dec_neg;
                o_state.cur_x = diag ? x_inc : i_state.cur_x;
                o_state.cur_y = y_inc;
                o_done        = (y_inc == i_state.stop);
            end
            OCT_STEEP_DOWN: begin
                diag          = !dec_neg && !dec_zero;
                o_state.cur_x = diag ? x_inc : i_state.cur_x;
                o_state.cur_y = y_dec;
                o_done        = (y_dec == i_state.stop);
            end
            default: begin
                o_done = 1'b0;
            end
        endcase

        o_state.decision = i_state.decision
                         + (diag ? i_state.inc_diagonal : i_state.inc_straight);
        o_state.active   = !o_done;
    end

endmodule

[hw/rtl/midpoint_line_rasterizer_core.sv]
// Top level of the midpoint line rasterizer: beat registers, line state and output stage.
//
// The slave channel takes one request per beat. A start beat (tuser low) carries both
// endpoints and a colour; it emits the first pixel of the line, or nothing for a line
// whose endpoints coincide. A step beat (tuser high) emits the next pixel of the active
// line, with tlast on the end point; a step without an active line emits nothing, and
// a start beat abandons any line still in progress.
// Each accepted beat lands in an input register; the setup or step logic runs on it and,
// once the output stage advances, its pixel is written to the output register that drives
// the master channel. Throughput is one request per clock while the master side does not
// stall, bounded by the registered update of the decision value and the current point.
// When the master side stalls, the output register holds its pixel and the input
// register holds one more request; the slave side then deasserts tready until the
// pixel is taken.
// Reset clears the valid flags of both register stages and drops any active line.
module midpoint_line_rasterizer_core import mlr_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, end_x, end_y, colour
    input  logic [S_DATA_BITS-1:0] s_axis_tdata,
    // req_type
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pixel_x, pixel_y, pixel_colour
    output logic [M_DATA_BITS-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic        r_in_valid;
    t_req        r_in_req;
    t_coord      r_in_start_x;
    t_coord      r_in_start_y;
    t_coord      r_in_end_x;
    t_coord      r_in_end_y;
    t_colour     r_in_colour;

    t_line_state r_state;
    t_line_state n_state;
    t_colour     r_colour;
    t_colour     n_colour;

    logic        r_out_valid;
    logic        n_out_valid;
    t_coord      r_out_x;
    t_coord      n_out_x;
    t_coord      r_out_y;
    t_coord      n_out_y;
    t_colour     r_out_colour;
    t_colour     n_out_colour;
    logic        r_out_last;
    logic        n_out_last;

    logic        advance;
    logic        s_accept;
    t_line_state setup_state;
    logic        setup_emit;
    t_line_state step_state;
    logic        step_done;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    mlr_setup u_setup (
        .i_start_x (r_in_start_x),
        .i_start_y (r_in_start_y),
        .i_end_x   (r_in_end_x),
        .i_end_y   (r_in_end_y),
        .o_state   (setup_state),
        .o_emit    (setup_emit)
    );

    mlr_step u_step (
        .i_state (r_state),
        .o_state (step_state),
        .o_done  (step_done)
    );

    always_comb begin
        n_state      = r_state;
        n_colour     = r_colour;
        n_out_valid  = 1'b0;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_colour = r_out_colour;
        n_out_last   = r_out_last;
        if (r_in_valid) begin
            case (r_in_req)
                REQ_START: begin
                    n_state      = setup_state;
                    n_colour     = r_in_colour;
                    n_out_valid  = setup_emit;
                    n_out_x      = setup_state.cur_x;
                    n_out_y      = setup_state.cur_y;
                    n_out_colour = r_in_colour;
                    n_out_last   = 1'b0;
                end
                REQ_STEP: begin
                    if (r_state.active) begin
                        n_state      = step_state;
                        n_out_valid  = 1'b1;
                        n_out_x      = step_state.cur_x;
                        n_out_y      = step_state.cur_y;
                        n_out_colour = r_colour;
                        n_out_last   = step_done;
                    end
                end
                default: begin
                    n_out_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_req     <= t_req'(s_axis_tuser);
            r_in_start_x <= s_axis_tdata[0*COORD_BITS +: COORD_BITS];
            r_in_start_y <= s_axis_tdata[1*COORD_BITS +: COORD_BITS];
            r_in_end_x   <= s_axis_tdata[2*COORD_BITS +: COORD_BITS];
            r_in_end_y   <= s_axis_tdata[3*COORD_BITS +: COORD_BITS];
            r_in_colour  <= s_axis_tdata[4*COORD_BITS +: COLOUR_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_colour    <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_state     <= n_state;
            r_colour    <= n_colour;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_x      <= n_out_x;
            r_out_y      <= n_out_y;
            r_out_colour <= n_out_colour;
            r_out_last   <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_BITS'({r_out_colour, r_out_y, r_out_x});
    assign m_axis_tlast  = r_out_last;

endmodule

[hw/rtl/mlr_checker.sv]
// Port-level checker for the line rasterizer and its bind to the top level.
`include "midpoint_line_rasterizer_core_macros.svh"

module mlr_checker import mlr_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tready,
    input logic                   i_m_tvalid,
    input logic                   i_m_tready,
    input logic [M_DATA_BITS-1:0] i_m_tdata,
    input logic                   i_m_tlast
);

    `MLR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast), "Stalled output beat changed or dropped.")
    `MLR_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_m_tvalid, i_s_tready, "Input not ready while the output stage is empty.")
    `MLR_ASSERT_NOW(a_ready_on_drain, i_clk, i_rst_n, i_m_tvalid && i_m_tready, i_s_tready, "Input not ready while the output beat drains.")
    `MLR_ASSERT_NOW(a_quiet_after_reset, i_clk, i_rst_n, $past(!i_rst_n), !i_m_tvalid, "Output beat present right after reset.")

endmodule

bind midpoint_line_rasterizer_core mlr_checker u_mlr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast)
);
